[hdl/touch_grid_key_tracker_core_defines.svh]
// assertion macros shared by the key tracker modules
`ifndef TOUCH_GRID_KEY_TRACKER_CORE_DEFINES_SVH
`define TOUCH_GRID_KEY_TRACKER_CORE_DEFINES_SVH

// same-cycle implication, checked on every rising edge outside reset
`define TGK_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on every rising edge outside reset
`define TGK_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/tgk_pkg.sv]
// shared constants, types and helper functions of the touch grid key tracker
package tgk_pkg;

    // grid geometry constants
    localparam int CELL_GAP  = 4;
    localparam int MAX_SIDE  = 8;

    // restoring divider step counts
    localparam int CS_STEPS  = 15;
    localparam int POS_STEPS = 3;
    localparam int CNT_W     = $clog2(CS_STEPS);

    // event kinds
    typedef enum logic [1:0] {
        FUNC_PRESS   = 2'd0,
        FUNC_STAY    = 2'd1,
        FUNC_RELEASE = 2'd2,
        FUNC_CLICK   = 2'd3
    } func_t;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_ORIGIN_X     = 3'd0,
        REG_ORIGIN_Y     = 3'd1,
        REG_GRID_WIDTH   = 3'd2,
        REG_GRID_HEIGHT  = 3'd3,
        REG_ROW_COUNT    = 3'd4,
        REG_COLUMN_COUNT = 3'd5,
        REG_EMPTY_MASK   = 3'd6
    } reg_index_t;

    // which division the shared divider runs
    typedef enum logic [1:0] {
        DIV_W = 2'd0,
        DIV_H = 2'd1,
        DIV_X = 2'd2,
        DIV_Y = 2'd3
    } div_sel_t;

    // controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV_W,
        ST_LD_H,
        ST_DIV_H,
        ST_LD_X,
        ST_DIV_X,
        ST_LD_Y,
        ST_DIV_Y,
        ST_DECIDE
    } state_t;

    // controller to datapath commands
    typedef struct packed {
        logic     in_load;
        logic     div_load;
        div_sel_t div_sel;
        logic     div_step;
        logic     decide;
    } cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic out_full;
    } stat_t;

    // saturate a row or column count to the largest supported side
    function automatic logic [3:0] eff_count(logic [3:0] n);
        return (n > 4'(MAX_SIDE)) ? 4'(MAX_SIDE) : n;
    endfunction

    // total width of the gap bands between n cells
    function automatic logic [16:0] gap_span(logic [3:0] n);
        logic [16:0] span;
        span = (n == 4'd0) ? 17'd0 : 17'((17'(n) - 17'd1) * 17'(CELL_GAP));
        return span;
    endfunction

endpackage

[hdl/tgk_channels.sv]
// handshake channel interfaces of the touch grid key tracker

// touch event channel
interface tgk_in_if;
    logic               valid;
    logic               ready;
    logic        [1:0]  func;
    logic signed [15:0] touch_x;
    logic signed [15:0] touch_y;

    modport source (output valid, output func, output touch_x, output touch_y,
                    input ready);
    modport sink   (input valid, input func, input touch_x, input touch_y,
                    output ready);
endinterface

// result channel
interface tgk_out_if;
    logic       valid;
    logic       ready;
    logic       consumed;
    logic       click_valid;
    logic [5:0] click_index;
    logic       redraw_valid;
    logic [5:0] redraw_index;

    modport source (output valid, output consumed, output click_valid,
                    output click_index, output redraw_valid, output redraw_index,
                    input ready);
    modport sink   (input valid, input consumed, input click_valid,
                    input click_index, input redraw_valid, input redraw_index,
                    output ready);
endinterface

// configuration write channel
interface tgk_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [63:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[hdl/tgk_div.sv]
// shared restoring divider, one quotient bit per cycle while step is high
module tgk_div (
    input  logic        clk,
    input  logic        load,
    input  logic        step,
    input  logic [15:0] dividend,
    input  logic [17:0] divisor,
    output logic [14:0] quotient,
    output logic [15:0] remainder
);
    logic [15:0] rem_reg, rem_next;
    logic [17:0] dsh_reg, dsh_next;
    logic [14:0] quo_reg, quo_next;
    logic [17:0] diff;
    logic        fits;

    // trial subtract of the shifted divisor
    always_comb
    begin
        diff     = {2'b00, rem_reg} - dsh_reg;
        fits     = ({2'b00, rem_reg} >= dsh_reg);
        rem_next = rem_reg;
        dsh_next = dsh_reg;
        quo_next = quo_reg;
        if (load)
        begin
            rem_next = dividend;
            dsh_next = divisor;
            quo_next = '0;
        end
        else if (step)
        begin
            rem_next = fits ? diff[15:0] : rem_reg;
            dsh_next = {1'b0, dsh_reg[17:1]};
            quo_next = {quo_reg[13:0], fits};
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsh_reg <= dsh_next;
        quo_reg <= quo_next;
    end

    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

[hdl/tgk_ctrl.sv]
// sequencer that steps the datapath through one touch event
`include "touch_grid_key_tracker_core_defines.svh"

module tgk_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    output tgk_pkg::cmd_t  cmd,
    input  tgk_pkg::stat_t stat
);
    import tgk_pkg::*;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;

    // state and step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        cmd          = '0;
        cmd.div_sel  = DIV_W;
        in_ready     = (state_reg == ST_IDLE);
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.in_load  = 1'b1;
                    cmd.div_load = 1'b1;
                    cmd.div_sel  = DIV_W;
                    cnt_next     = CNT_W'(CS_STEPS - 1);
                    state_next   = ST_DIV_W;
                end
            end
            ST_DIV_W:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                    state_next = ST_LD_H;
            end
            ST_LD_H:
            begin
                cmd.div_load = 1'b1;
                cmd.div_sel  = DIV_H;
                cnt_next     = CNT_W'(CS_STEPS - 1);
                state_next   = ST_DIV_H;
            end
            ST_DIV_H:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                    state_next = ST_LD_X;
            end
            ST_LD_X:
            begin
                cmd.div_load = 1'b1;
                cmd.div_sel  = DIV_X;
                cnt_next     = CNT_W'(POS_STEPS - 1);
                state_next   = ST_DIV_X;
            end
            ST_DIV_X:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                    state_next = ST_LD_Y;
            end
            ST_LD_Y:
            begin
                cmd.div_load = 1'b1;
                cmd.div_sel  = DIV_Y;
                cnt_next     = CNT_W'(POS_STEPS - 1);
                state_next   = ST_DIV_Y;
            end
            ST_DIV_Y:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                    state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                if (!stat.out_full)
                begin
                    cmd.decide = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // checks
    `TGK_ASSERT_NOW(a_decide_free, cmd.decide, !stat.out_full, "decide into a full result word")
    `TGK_ASSERT_NEXT(a_accept_starts, in_valid && in_ready,
        state_reg == ST_DIV_W && cnt_reg == CNT_W'(CS_STEPS - 1), "accept did not start division")
    `TGK_ASSERT_NEXT(a_width_div_len, state_reg == ST_DIV_W && cnt_reg == '0,
        state_reg == ST_LD_H, "width division overran")

endmodule

[hdl/tgk_dp.sv]
// datapath: configuration, hit test arithmetic, key tracking and result word
`include "touch_grid_key_tracker_core_defines.svh"

module tgk_dp (
    input  logic               clk,
    input  logic               rst_n,
    input  logic        [1:0]  func,
    input  logic signed [15:0] touch_x,
    input  logic signed [15:0] touch_y,
    tgk_out_if.source          results,
    tgk_cfg_if.sink            cfg,
    input  tgk_pkg::cmd_t      cmd,
    output tgk_pkg::stat_t     stat
);
    import tgk_pkg::*;

    // configuration registers
    logic signed [15:0] origin_x_reg, origin_y_reg;
    logic [14:0]        width_reg, height_reg;
    logic [3:0]         rows_reg, cols_reg;
    logic [63:0]        empty_reg;

    // event and intermediate registers
    func_t              func_reg;
    logic signed [15:0] px_reg, py_reg;
    logic [14:0]        cw_reg, ch_reg;
    logic               cw_ok_reg, ch_ok_reg;
    logic               miss_x_reg, miss_y_reg, x_ok_reg;
    logic [2:0]         col_reg;

    // tracker state
    logic               armed_valid_reg, armed_valid_next;
    logic [5:0]         armed_index_reg, armed_index_next;
    logic               key_held_reg, key_held_next;

    // result word
    logic               out_full_reg;
    logic               consumed_reg, consumed_next;
    logic               click_reg, click_next;
    logic [5:0]         click_idx_reg, click_idx_next;
    logic               redraw_reg, redraw_next;
    logic [5:0]         redraw_idx_reg, redraw_idx_next;

    // combinational terms
    logic [3:0]         rows_eff, cols_eff;
    logic [16:0]        num_w, num_h;
    logic               bad_w, bad_h;
    logic [15:0]        dx, dy;
    logic signed [16:0] rx, ry;
    logic               miss_x, miss_y;
    logic [15:0]        div_dividend;
    logic [17:0]        div_divisor;
    logic [14:0]        quo;
    logic [15:0]        rem;
    logic               y_ok, hit, fits, empty;
    logic [2:0]         row;
    logic [6:0]         idx_full;
    logic [5:0]         hit_index;
    logic [6:0]         cell_total;

    // geometry from configuration
    always_comb
    begin
        rows_eff = eff_count(rows_reg);
        cols_eff = eff_count(cols_reg);
        num_w    = {2'b00, width_reg} - gap_span(cols_eff);
        num_h    = {2'b00, height_reg} - gap_span(rows_eff);
        bad_w    = (cols_eff == 4'd0) || num_w[16] || (num_w == 17'd0);
        bad_h    = (rows_eff == 4'd0) || num_h[16] || (num_h == 17'd0);
        dx       = {1'b0, cw_reg} + 16'(CELL_GAP);
        dy       = {1'b0, ch_reg} + 16'(CELL_GAP);
        rx       = {px_reg[15], px_reg} - {origin_x_reg[15], origin_x_reg};
        ry       = {py_reg[15], py_reg} - {origin_y_reg[15], origin_y_reg};
        miss_x   = rx[16] || ({3'b000, rx[15:0]} >= {dx, 3'b000});
        miss_y   = ry[16] || ({3'b000, ry[15:0]} >= {dy, 3'b000});
    end

    // divider operand select
    always_comb
    begin
        case (cmd.div_sel)
            DIV_W:
            begin
                div_dividend = num_w[15:0];
                div_divisor  = {cols_eff, 14'd0};
            end
            DIV_H:
            begin
                div_dividend = num_h[15:0];
                div_divisor  = {rows_eff, 14'd0};
            end
            DIV_X:
            begin
                div_dividend = rx[15:0];
                div_divisor  = {dx, 2'b00};
            end
            default:
            begin
                div_dividend = ry[15:0];
                div_divisor  = {dy, 2'b00};
            end
        endcase
    end

    tgk_div u_div (
        .clk       (clk),
        .load      (cmd.div_load),
        .step      (cmd.div_step),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .quotient  (quo),
        .remainder (rem)
    );

    // configuration writes
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg <= '0;
            origin_y_reg <= '0;
            width_reg    <= '0;
            height_reg   <= '0;
            rows_reg     <= '0;
            cols_reg     <= '0;
            empty_reg    <= '1;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_ORIGIN_X:     origin_x_reg <= cfg.data[15:0];
                REG_ORIGIN_Y:     origin_y_reg <= cfg.data[15:0];
                REG_GRID_WIDTH:   width_reg    <= cfg.data[14:0];
                REG_GRID_HEIGHT:  height_reg   <= cfg.data[14:0];
                REG_ROW_COUNT:    rows_reg     <= cfg.data[3:0];
                REG_COLUMN_COUNT: cols_reg     <= cfg.data[3:0];
                REG_EMPTY_MASK:   empty_reg    <= cfg.data;
                default:          ;
            endcase
        end
    end

    // event capture and per-axis results as each division finishes
    always_ff @(posedge clk)
    begin
        if (cmd.in_load)
        begin
            func_reg <= func_t'(func);
            px_reg   <= touch_x;
            py_reg   <= touch_y;
        end
        if (cmd.div_load)
        begin
            case (cmd.div_sel)
                DIV_H:
                begin
                    cw_reg    <= quo;
                    cw_ok_reg <= !bad_w && (quo != 15'd0);
                end
                DIV_X:
                begin
                    ch_reg     <= quo;
                    ch_ok_reg  <= !bad_h && (quo != 15'd0);
                    miss_x_reg <= miss_x;
                end
                DIV_Y:
                begin
                    col_reg    <= quo[2:0];
                    x_ok_reg   <= !miss_x_reg && ({1'b0, quo[2:0]} < cols_eff)
                                  && (rem < {1'b0, cw_reg});
                    miss_y_reg <= miss_y;
                end
                default: ;
            endcase
        end
    end

    // hit test close-out and key tracking
    always_comb
    begin
        row        = quo[2:0];
        y_ok       = !miss_y_reg && ({1'b0, row} < rows_eff) && (rem < {1'b0, ch_reg});
        hit        = cw_ok_reg && ch_ok_reg && x_ok_reg && y_ok;
        idx_full   = 7'({4'b0000, row} * {3'b000, cols_eff}) + {4'b0000, col_reg};
        hit_index  = idx_full[5:0];
        empty      = empty_reg[hit_index];
        cell_total = 7'({3'b000, rows_eff} * {3'b000, cols_eff});
        fits       = cw_ok_reg && ch_ok_reg && ({1'b0, armed_index_reg} < cell_total);

        armed_valid_next = armed_valid_reg;
        armed_index_next = armed_index_reg;
        key_held_next    = key_held_reg;
        consumed_next    = 1'b0;
        click_next       = 1'b0;
        click_idx_next   = '0;
        redraw_next      = 1'b0;
        redraw_idx_next  = '0;
        case (func_reg)
            FUNC_PRESS:
            begin
                if (hit && !empty)
                begin
                    armed_valid_next = 1'b1;
                    armed_index_next = hit_index;
                    key_held_next    = 1'b1;
                    redraw_next      = 1'b1;
                    redraw_idx_next  = hit_index;
                    consumed_next    = 1'b1;
                end
                else
                begin
                    armed_valid_next = 1'b0;
                    key_held_next    = 1'b0;
                end
            end
            FUNC_STAY:
            begin
                if (armed_valid_reg)
                begin
                    if (!hit || (hit_index != armed_index_reg))
                    begin
                        if (key_held_reg)
                        begin
                            key_held_next = 1'b0;
                            if (fits)
                            begin
                                redraw_next     = 1'b1;
                                redraw_idx_next = armed_index_reg;
                            end
                        end
                        armed_valid_next = 1'b0;
                    end
                    consumed_next = 1'b1;
                end
            end
            FUNC_RELEASE:
            begin
                if (key_held_reg)
                begin
                    key_held_next = 1'b0;
                    if (armed_valid_reg && fits)
                    begin
                        redraw_next     = 1'b1;
                        redraw_idx_next = armed_index_reg;
                    end
                end
                consumed_next = armed_valid_reg;
            end
            default:
            begin
                if (hit && armed_valid_reg && (hit_index == armed_index_reg) && !empty)
                begin
                    click_next     = 1'b1;
                    click_idx_next = hit_index;
                    consumed_next  = 1'b1;
                end
                armed_valid_next = 1'b0;
            end
        endcase
    end

    // tracker state and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_valid_reg <= 1'b0;
            armed_index_reg <= '0;
            key_held_reg    <= 1'b0;
            out_full_reg    <= 1'b0;
        end
        else if (cmd.decide)
        begin
            armed_valid_reg <= armed_valid_next;
            armed_index_reg <= armed_index_next;
            key_held_reg    <= key_held_next;
            out_full_reg    <= 1'b1;
        end
        else if (results.ready)
        begin
            out_full_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (cmd.decide)
        begin
            consumed_reg   <= consumed_next;
            click_reg      <= click_next;
            click_idx_reg  <= click_idx_next;
            redraw_reg     <= redraw_next;
            redraw_idx_reg <= redraw_idx_next;
        end
    end

    assign results.valid        = out_full_reg;
    assign results.consumed     = consumed_reg;
    assign results.click_valid  = click_reg;
    assign results.click_index  = click_idx_reg;
    assign results.redraw_valid = redraw_reg;
    assign results.redraw_index = redraw_idx_reg;
    assign stat.out_full        = out_full_reg;

    // checks
    `TGK_ASSERT_NEXT(a_decide_fills, cmd.decide, out_full_reg, "decide left result word empty")
    `TGK_ASSERT_NOW(a_click_consumed, results.valid && results.click_valid,
        results.consumed, "click reported on an event not consumed")
    `TGK_ASSERT_NOW(a_single_report, results.valid,
        !(results.click_valid && results.redraw_valid), "click and redraw in one word")

endmodule

[hdl/touch_grid_key_tracker_core.sv]
// Touch grid key tracker top level. Each touch event word runs through one
// shared restoring divider, one quotient bit per cycle while a division
// steps: 15 bits each for cell width and cell height, 3 each for the column
// and row. The width division is loaded on the accept, each later division
// in a load state of its own, and a decision state ends the event. The
// result word sits in an output register; the next event is accepted while
// it waits, and that event only stalls at its decision cycle if the earlier
// word is still not taken. Configuration writes are taken in any cycle and
// must only be issued while no event is in flight.
module touch_grid_key_tracker_core (
    input logic       clk,
    input logic       rst_n,
    tgk_in_if.sink    events,
    tgk_out_if.source results,
    tgk_cfg_if.sink   cfg
);
    import tgk_pkg::*;

    cmd_t  cmd;
    stat_t stat;
    logic  in_ready;

    assign events.ready = in_ready;

    // sequencer
    tgk_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (events.valid),
        .in_ready (in_ready),
        .cmd      (cmd),
        .stat     (stat)
    );

    // arithmetic, state and result word
    tgk_dp u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .func    (events.func),
        .touch_x (events.touch_x),
        .touch_y (events.touch_y),
        .results (results),
        .cfg     (cfg),
        .cmd     (cmd),
        .stat    (stat)
    );

endmodule

[tb/tb_touch_grid_key_tracker_core.sv]
// self-checking testbench of the touch grid key tracker core with a key state predictor
module tb_touch_grid_key_tracker_core;
    timeunit 1ns;
    timeprecision 1ps;

    import tgk_pkg::*;

    localparam int LATENCY     = 41;
    localparam int CYCLE_LIMIT = 500000;
    localparam int PRINT_LIMIT = 40;

    // one expected result word
    typedef struct packed {
        logic       consumed;
        logic       click_valid;
        logic [5:0] click_index;
        logic       redraw_valid;
        logic [5:0] redraw_index;
    } key_outcome_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    tgk_in_if  events_if();
    tgk_out_if results_if();
    tgk_cfg_if cfg_if();

    touch_grid_key_tracker_core DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .events  (events_if),
        .results (results_if),
        .cfg     (cfg_if)
    );

    // predictor copy of the registers and the key state
    int           org_x;
    int           org_y;
    int           span_w;
    int           span_h;
    logic [3:0]   rows_reg;
    logic [3:0]   cols_reg;
    logic [63:0]  empty_cells;
    bit           key_armed;
    bit           key_down;
    logic [5:0]   armed_cell;

    key_outcome_t pending_outcomes[$];
    int           in_idle_pct     = 24;
    int           out_idle_pct    = 24;
    int           out_hold_cycles = 0;
    int           mismatch_count  = 0;
    int           events_sent     = 0;
    int           cycle_count     = 0;

    // clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // row or column count clipped to the largest side
    function automatic int side_count(logic [3:0] n);
        return (n > MAX_SIDE) ? MAX_SIDE : int'(n);
    endfunction

    // cell size along one axis, zero when the span cannot hold the cells
    function automatic int pitch_size(int span, int n);
        int num;
        if (n == 0)
            return 0;
        num = span - (n - 1) * CELL_GAP;
        if (num <= 0)
            return 0;
        return num / n;
    endfunction

    // whether a key index still exists in the current geometry
    function automatic bit cell_on_grid(logic [5:0] idx);
        int rows;
        int cols;
        rows = side_count(rows_reg);
        cols = side_count(cols_reg);
        if (rows == 0 || cols == 0 || int'(idx) >= rows * cols)
            return 1'b0;
        return pitch_size(span_w, cols) > 0 && pitch_size(span_h, rows) > 0;
    endfunction

    // hit test of a touch point against the grid
    function automatic bit locate_key(logic signed [15:0] px, logic signed [15:0] py,
                                      output logic [5:0] idx);
        int rows;
        int cols;
        int cw;
        int ch;
        int rx;
        int ry;
        int col;
        int row;
        idx  = '0;
        rows = side_count(rows_reg);
        cols = side_count(cols_reg);
        cw   = pitch_size(span_w, cols);
        ch   = pitch_size(span_h, rows);
        if (cw <= 0 || ch <= 0)
            return 1'b0;
        rx = int'(px) - org_x;
        ry = int'(py) - org_y;
        if (rx < 0 || ry < 0)
            return 1'b0;
        col = rx / (cw + CELL_GAP);
        row = ry / (ch + CELL_GAP);
        if (col >= cols || row >= rows)
            return 1'b0;
        if (rx - col * (cw + CELL_GAP) >= cw || ry - row * (ch + CELL_GAP) >= ch)
            return 1'b0;
        idx = 6'(row * cols + col);
        return 1'b1;
    endfunction

    // next key state and the result word of one touch event
    function automatic key_outcome_t predict_event(func_t kind, logic signed [15:0] px,
                                                   logic signed [15:0] py);
        key_outcome_t res;
        logic [5:0]   idx;
        bit           hit;
        res = '0;
        case (kind)
            FUNC_PRESS:
            begin
                hit = locate_key(px, py, idx);
                if (hit && !empty_cells[idx])
                begin
                    key_armed        = 1'b1;
                    key_down         = 1'b1;
                    armed_cell       = idx;
                    res.redraw_valid = 1'b1;
                    res.redraw_index = idx;
                    res.consumed     = 1'b1;
                end
                else
                begin
                    key_armed = 1'b0;
                    key_down  = 1'b0;
                end
            end
            FUNC_STAY:
            begin
                if (key_armed)
                begin
                    hit = locate_key(px, py, idx);
                    if (!hit || idx != armed_cell)
                    begin
                        if (key_down)
                        begin
                            key_down = 1'b0;
                            if (cell_on_grid(armed_cell))
                            begin
                                res.redraw_valid = 1'b1;
                                res.redraw_index = armed_cell;
                            end
                        end
                        key_armed = 1'b0;
                    end
                    res.consumed = 1'b1;
                end
            end
            FUNC_RELEASE:
            begin
                if (key_down)
                begin
                    key_down = 1'b0;
                    if (key_armed && cell_on_grid(armed_cell))
                    begin
                        res.redraw_valid = 1'b1;
                        res.redraw_index = armed_cell;
                    end
                end
                res.consumed = key_armed;
            end
            FUNC_CLICK:
            begin
                hit = locate_key(px, py, idx);
                if (hit && key_armed && idx == armed_cell && !empty_cells[idx])
                begin
                    res.click_valid = 1'b1;
                    res.click_index = idx;
                    res.consumed    = 1'b1;
                end
                key_armed = 1'b0;
            end
        endcase
        return res;
    endfunction

    // count a mismatch and print a line for the first few
    task automatic flag_mismatch(string what);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
            $display("%0t: %s", $realtime, what);
    endtask

    // write every register, keeping valid high across the words
    task automatic load_grid(logic signed [15:0] ox, logic signed [15:0] oy,
                             logic [14:0] gw, logic [14:0] gh,
                             logic [3:0] rc, logic [3:0] cc, logic [63:0] mask);
        logic [63:0] word [7];
        word[REG_ORIGIN_X]     = {48'd0, ox};
        word[REG_ORIGIN_Y]     = {48'd0, oy};
        word[REG_GRID_WIDTH]   = {49'd0, gw};
        word[REG_GRID_HEIGHT]  = {49'd0, gh};
        word[REG_ROW_COUNT]    = {60'd0, rc};
        word[REG_COLUMN_COUNT] = {60'd0, cc};
        word[REG_EMPTY_MASK]   = mask;
        for (int i = 0; i < 7; i++)
        begin
            cfg_if.valid <= 1'b1;
            cfg_if.index <= reg_index_t'(i);
            cfg_if.data  <= word[i];
            do @(posedge clk); while (!cfg_if.ready);
        end
        cfg_if.valid <= 1'b0;
        org_x       = int'(ox);
        org_y       = int'(oy);
        span_w      = int'(gw);
        span_h      = int'(gh);
        rows_reg    = rc;
        cols_reg    = cc;
        empty_cells = mask;
    endtask

    // offer one event word, idling at random first
    task automatic send_event(func_t kind, logic signed [15:0] px, logic signed [15:0] py);
        if ($urandom_range(0, 99) < in_idle_pct)
        begin
            events_if.valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(0, 99) < in_idle_pct);
        end
        events_if.valid   <= 1'b1;
        events_if.func    <= kind;
        events_if.touch_x <= px;
        events_if.touch_y <= py;
        do @(posedge clk); while (!events_if.ready);
        pending_outcomes.push_back(predict_event(kind, px, py));
        events_sent++;
    endtask

    // stop offering and wait for every expected result word
    task automatic wait_drained();
        events_if.valid <= 1'b0;
        while (pending_outcomes.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // random key index inside the current grid
    function automatic logic [5:0] pick_key();
        int n;
        n = side_count(rows_reg) * side_count(cols_reg);
        if (n == 0)
            return 6'($urandom);
        return 6'($urandom_range(0, n - 1));
    endfunction

    // random point inside the given key
    function automatic void key_point(logic [5:0] idx, output logic signed [15:0] px,
                                      output logic signed [15:0] py);
        int cols;
        int cw;
        int ch;
        cols = side_count(cols_reg);
        cw   = pitch_size(span_w, cols);
        ch   = pitch_size(span_h, side_count(rows_reg));
        if (cols == 0 || cw <= 0 || ch <= 0)
        begin
            px = 16'($urandom);
            py = 16'($urandom);
            return;
        end
        px = 16'(org_x + (int'(idx) % cols) * (cw + CELL_GAP) + int'($urandom_range(0, cw - 1)));
        py = 16'(org_y + (int'(idx) / cols) * (ch + CELL_GAP) + int'($urandom_range(0, ch - 1)));
    endfunction

    // random point, anywhere or around the grid
    function automatic void any_point(output logic signed [15:0] px,
                                      output logic signed [15:0] py);
        if ($urandom_range(0, 1) == 0)
        begin
            px = 16'($urandom);
            py = 16'($urandom);
        end
        else
        begin
            px = 16'(org_x + int'($urandom_range(0, span_w + 16)) - 8);
            py = 16'(org_y + int'($urandom_range(0, span_h + 16)) - 8);
        end
    endfunction

    // random geometry, mostly well-fitting grids
    task automatic load_random_grid();
        int          rc;
        int          cc;
        int          cw;
        int          ch;
        int          gw;
        int          gh;
        int          ox;
        int          oy;
        logic [63:0] mask;
        rc = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(1, MAX_SIDE);
        cc = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(1, MAX_SIDE);
        cw = $urandom_range(1, 40);
        ch = $urandom_range(1, 40);
        gw = side_count(4'(cc));
        gw = (gw == 0) ? $urandom_range(0, 400)
                       : gw * cw + (gw - 1) * CELL_GAP + $urandom_range(0, gw - 1);
        gh = side_count(4'(rc));
        gh = (gh == 0) ? $urandom_range(0, 400)
                       : gh * ch + (gh - 1) * CELL_GAP + $urandom_range(0, gh - 1);
        if ($urandom_range(0, 9) == 0)
            gw = $urandom_range(0, 32767);
        if ($urandom_range(0, 9) == 0)
            gh = $urandom_range(0, 32767);
        ox = ($urandom_range(0, 4) == 0) ? int'($urandom) : int'($urandom_range(0, 1200)) - 600;
        oy = ($urandom_range(0, 4) == 0) ? int'($urandom) : int'($urandom_range(0, 1200)) - 600;
        case ($urandom_range(0, 3))
            0:       mask = '0;
            3:       mask = {$urandom, $urandom};
            default: mask = {$urandom, $urandom} & {$urandom, $urandom};
        endcase
        load_grid(16'(ox), 16'(oy), 15'(gw), 15'(gh), 4'(rc), 4'(cc), mask);
    endtask

    // press, a few stays, then a release, a click or a press; some loose events between
    task automatic run_sessions(int count);
        int                 stop_at;
        int                 stays;
        logic [5:0]         target;
        logic signed [15:0] px;
        logic signed [15:0] py;
        stop_at = events_sent + count;
        while (events_sent < stop_at)
        begin
            if ($urandom_range(0, 99) < 75)
            begin
                target = pick_key();
                key_point(target, px, py);
                send_event(FUNC_PRESS, px, py);
                stays = $urandom_range(0, 3);
                repeat (stays)
                begin
                    if ($urandom_range(0, 99) < 80)
                        key_point(target, px, py);
                    else
                        any_point(px, py);
                    send_event(FUNC_STAY, px, py);
                end
                case ($urandom_range(0, 9))
                    0, 1, 2, 3:
                    begin
                        any_point(px, py);
                        send_event(FUNC_RELEASE, px, py);
                    end
                    4, 5, 6, 7:
                    begin
                        key_point(target, px, py);
                        send_event(FUNC_CLICK, px, py);
                    end
                    8:
                    begin
                        any_point(px, py);
                        send_event(FUNC_CLICK, px, py);
                    end
                    default:
                    begin
                        any_point(px, py);
                        send_event(FUNC_PRESS, px, py);
                    end
                endcase
            end
            else
            begin
                any_point(px, py);
                send_event(func_t'($urandom_range(0, 3)), px, py);
            end
        end
    endtask

    // reset registers disable every hit
    task automatic test_reset_state();
        send_event(FUNC_PRESS, 16'sd0, 16'sd0);
        send_event(FUNC_STAY, -16'sd32768, 16'sd32767);
        send_event(FUNC_RELEASE, 16'sd0, 16'sd0);
        send_event(FUNC_CLICK, 16'sd32767, -16'sd32768);
        wait_drained();
    endtask

    // 3 x 4 grid of 20 x 10 keys at (100, 50), key 5 empty
    task automatic test_directed_keys();
        load_grid(16'sd100, 16'sd50, 15'd92, 15'd38, 4'd3, 4'd4, 64'h20);
        send_event(FUNC_PRESS, 16'sd100, 16'sd50);
        send_event(FUNC_STAY, 16'sd119, 16'sd59);
        // stay in the gap band disarms
        send_event(FUNC_STAY, 16'sd120, 16'sd50);
        send_event(FUNC_STAY, 16'sd0, 16'sd0);
        send_event(FUNC_PRESS, 16'sd143, 16'sd59);
        send_event(FUNC_RELEASE, 16'sd0, 16'sd0);
        send_event(FUNC_CLICK, 16'sd124, 16'sd50);
        // click on another key leaves the hold set
        send_event(FUNC_PRESS, 16'sd148, 16'sd64);
        send_event(FUNC_CLICK, 16'sd172, 16'sd64);
        send_event(FUNC_RELEASE, 16'sd148, 16'sd64);
        // misses left, above, right, below, empty key
        send_event(FUNC_PRESS, 16'sd99, 16'sd50);
        send_event(FUNC_PRESS, 16'sd100, 16'sd49);
        send_event(FUNC_PRESS, 16'sd196, 16'sd50);
        send_event(FUNC_PRESS, 16'sd100, 16'sd92);
        send_event(FUNC_PRESS, 16'sd124, 16'sd64);
        send_event(FUNC_CLICK, 16'sd100, 16'sd50);
        send_event(FUNC_PRESS, -16'sd32768, -16'sd32768);
        send_event(FUNC_PRESS, 16'sd32767, 16'sd32767);
        send_event(FUNC_PRESS, 16'sd191, 16'sd87);
        send_event(FUNC_CLICK, 16'sd191, 16'sd87);
        wait_drained();
    endtask

    // saturated counts, geometry changed under an armed key, extreme registers
    task automatic test_geometry_edges();
        load_grid(16'sd0, 16'sd0, 15'd200, 15'd200, 4'd15, 4'd9, 64'd0);
        send_event(FUNC_PRESS, 16'sd175, 16'sd175);
        wait_drained();
        // armed key 63 falls outside a 2 x 2 grid
        load_grid(16'sd0, 16'sd0, 15'd200, 15'd200, 4'd2, 4'd2, 64'd0);
        send_event(FUNC_STAY, 16'sd0, 16'sd0);
        send_event(FUNC_PRESS, 16'sd0, 16'sd0);
        wait_drained();
        // width too narrow for the gaps
        load_grid(16'sd0, 16'sd0, 15'd3, 15'd200, 4'd2, 4'd2, 64'd0);
        send_event(FUNC_RELEASE, 16'sd0, 16'sd0);
        send_event(FUNC_CLICK, 16'sd0, 16'sd0);
        wait_drained();
        load_grid(-16'sd32768, -16'sd32768, 15'd32767, 15'd32767, 4'd8, 4'd8, 64'd0);
        send_event(FUNC_PRESS, -16'sd32768, -16'sd32768);
        send_event(FUNC_PRESS, 16'sd32767, 16'sd32767);
        send_event(FUNC_PRESS, -16'sd4096, -16'sd4096);
        send_event(FUNC_CLICK, -16'sd4096, -16'sd4096);
        wait_drained();
        load_grid(16'sd32767, 16'sd32767, 15'd0, 15'd0, 4'd0, 4'd0, '1);
        send_event(FUNC_PRESS, 16'sd32767, 16'sd32767);
        wait_drained();
        load_grid(16'sd0, 16'sd0, 15'd7, 15'd32767, 4'd1, 4'd1, 64'd0);
        send_event(FUNC_PRESS, 16'sd0, 16'sd0);
        send_event(FUNC_CLICK, 16'sd6, 16'sd32767);
        wait_drained();
    endtask

    // receiver holds off while the sender keeps offering words
    task automatic test_backpressure();
        load_random_grid();
        in_idle_pct     = 0;
        out_hold_cycles = 400;
        run_sessions(14);
        wait_drained();
        in_idle_pct = 24;
    endtask

    // random geometry phases of key sessions, one phase without idling
    task automatic test_random_sessions();
        for (int phase = 0; phase < 6; phase++)
        begin
            load_random_grid();
            in_idle_pct  = (phase == 2) ? 0 : 24;
            out_idle_pct = (phase == 2) ? 0 : 24;
            run_sessions(100);
            wait_drained();
        end
    endtask

    // result checker and receiver ready
    initial
    begin
        key_outcome_t got;
        key_outcome_t want;
        results_if.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (results_if.valid && results_if.ready)
            begin
                got.consumed     = results_if.consumed;
                got.click_valid  = results_if.click_valid;
                got.click_index  = results_if.click_index;
                got.redraw_valid = results_if.redraw_valid;
                got.redraw_index = results_if.redraw_index;
                if (pending_outcomes.size() == 0)
                    flag_mismatch("result word with nothing expected");
                else
                begin
                    want = pending_outcomes.pop_front();
                    if (got.consumed !== want.consumed)
                        flag_mismatch($sformatf("consumed %b, expected %b",
                                                got.consumed, want.consumed));
                    if (got.click_valid !== want.click_valid)
                        flag_mismatch($sformatf("click_valid %b, expected %b",
                                                got.click_valid, want.click_valid));
                    if (got.click_index !== want.click_index)
                        flag_mismatch($sformatf("click_index %0d, expected %0d",
                                                got.click_index, want.click_index));
                    if (got.redraw_valid !== want.redraw_valid)
                        flag_mismatch($sformatf("redraw_valid %b, expected %b",
                                                got.redraw_valid, want.redraw_valid));
                    if (got.redraw_index !== want.redraw_index)
                        flag_mismatch($sformatf("redraw_index %0d, expected %0d",
                                                got.redraw_index, want.redraw_index));
                end
            end
            // long hold-off first, random stalls otherwise
            if (out_hold_cycles > 0)
            begin
                results_if.ready <= 1'b0;
                out_hold_cycles--;
            end
            else
                results_if.ready <= ($urandom_range(0, 99) >= out_idle_pct);
        end
    end

    // cycle limit
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // reset, test sequence and final verdict
    initial
    begin
        events_if.valid   <= 1'b0;
        events_if.func    <= FUNC_PRESS;
        events_if.touch_x <= '0;
        events_if.touch_y <= '0;
        cfg_if.valid      <= 1'b0;
        cfg_if.index      <= REG_ORIGIN_X;
        cfg_if.data       <= '0;
        org_x       = 0;
        org_y       = 0;
        span_w      = 0;
        span_h      = 0;
        rows_reg    = '0;
        cols_reg    = '0;
        empty_cells = '1;
        key_armed   = 1'b0;
        key_down    = 1'b0;
        armed_cell  = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_directed_keys();
        test_geometry_edges();
        test_backpressure();
        test_random_sessions();

        wait_drained();
        repeat (LATENCY + 20) @(posedge clk);
        if (pending_outcomes.size() != 0)
            flag_mismatch("expected result words never arrived");
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
